// File: rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types and constants of the centroid tracker with line crossing.
// ----------------------------------------------------------------------------
package ctl_pkg;

	localparam int unsigned CFG_IDX_BITS   = 1;
	localparam int unsigned SLOT_OUT_BITS  = 4;
	localparam int unsigned MAX_DIST_RESET = 20;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MID_LINE_X   = 1'b0,
		REG_MAX_DISTANCE = 1'b1
	} ctl_reg_t;

	// probe moving down the chain
	typedef struct packed {
		logic live;
		logic found;
		logic cand;
	} ctl_probe_t;

	// entry write broadcast to the chain
	typedef struct packed {
		logic en;
		logic add;
	} ctl_wr_t;

endpackage

// File: rtl/ctl_cell.sv
// ----------------------------------------------------------------------------
// ctl_cell
// One table entry: holds a center and a velocity, squares its distance to the
// passing probe and folds the previous entry's distance into the running best.
// ----------------------------------------------------------------------------
module ctl_cell #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned IW         = 4,
	parameter int unsigned CW         = 5,
	parameter int unsigned SLOT       = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CW-1:0]             count,
	input  ctl_pkg::ctl_wr_t          wr,
	input  logic [IW-1:0]             wr_slot,
	input  logic [COORD_BITS:0]       wr_cx,
	input  logic [COORD_BITS:0]       wr_cy,
	input  ctl_pkg::ctl_probe_t       ctl_in,
	input  logic [COORD_BITS:0]       cx_in,
	input  logic [COORD_BITS:0]       cy_in,
	input  logic [2*COORD_BITS+5:0]   sq_x_in,
	input  logic [2*COORD_BITS+5:0]   sq_y_in,
	input  logic [COORD_BITS:0]       cand_x_in,
	input  logic [2*COORD_BITS-1:0]   best_in,
	input  logic [IW-1:0]             win_in,
	input  logic [COORD_BITS:0]       old_x_in,
	output ctl_pkg::ctl_probe_t       ctl_out,
	output logic [COORD_BITS:0]       cx_out,
	output logic [COORD_BITS:0]       cy_out,
	output logic [2*COORD_BITS+5:0]   sq_x_out,
	output logic [2*COORD_BITS+5:0]   sq_y_out,
	output logic [COORD_BITS:0]       cand_x_out,
	output logic [2*COORD_BITS-1:0]   best_out,
	output logic [IW-1:0]             win_out,
	output logic [COORD_BITS:0]       old_x_out
);

	localparam int unsigned DW   = COORD_BITS + 3;
	localparam int unsigned SQW  = 2 * DW;
	localparam int unsigned SW   = SQW + 1;
	localparam int unsigned BW   = 2 * COORD_BITS;
	localparam int unsigned PW   = COORD_BITS + 1;
	localparam int unsigned VW   = COORD_BITS + 2;
	localparam int unsigned PREV = (SLOT == 0) ? 0 : SLOT - 1;

	logic [PW-1:0]        ctr_x_q, ctr_y_q;
	logic signed [VW-1:0] spd_x_q, spd_y_q;

	logic                  entry_ok;
	logic                  take;
	logic                  hit;
	logic [SW-1:0]         sum;
	logic signed [DW-1:0]  px, py, dx, dy;
	logic signed [SQW-1:0] mx, my;
	logic signed [VW-1:0]  nspd_x, nspd_y;

	ctl_pkg::ctl_probe_t   ctl_s1;
	logic [PW-1:0]         cx_s1, cy_s1, cand_x_s1, old_x_s1;
	logic [SQW-1:0]        sq_x_s1, sq_y_s1;
	logic [BW-1:0]         best_s1;
	logic [IW-1:0]         win_s1;

	assign entry_ok = count > CW'(SLOT);

	assign px = DW'($signed({1'b0, ctr_x_q})) + DW'(spd_x_q);
	assign py = DW'($signed({1'b0, ctr_y_q})) + DW'(spd_y_q);
	assign dx = px - DW'($signed({1'b0, cx_in}));
	assign dy = py - DW'($signed({1'b0, cy_in}));
	assign mx = dx * dx;
	assign my = dy * dy;

	assign sum  = SW'(sq_x_in) + SW'(sq_y_in);
	assign take = ctl_in.live && ctl_in.cand && (sum < SW'(best_in));

	assign hit    = wr.en && (wr_slot == IW'(SLOT));
	assign nspd_x = $signed({1'b0, wr_cx}) - $signed({1'b0, ctr_x_q});
	assign nspd_y = $signed({1'b0, wr_cy}) - $signed({1'b0, ctr_y_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.live  <= ctl_in.live;
			ctl_s1.found <= ctl_in.found | take;
			ctl_s1.cand  <= ctl_in.live & entry_ok;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1     <= cx_in;
		cy_s1     <= cy_in;
		sq_x_s1   <= SQW'(mx);
		sq_y_s1   <= SQW'(my);
		cand_x_s1 <= ctr_x_q;
		if (take) begin
			best_s1  <= sum[BW-1:0];
			win_s1   <= IW'(PREV);
			old_x_s1 <= cand_x_in;
		end else begin
			best_s1  <= best_in;
			win_s1   <= win_in;
			old_x_s1 <= old_x_in;
		end
		if (hit) begin
			ctr_x_q <= wr_cx;
			ctr_y_q <= wr_cy;
			if (wr.add) begin
				spd_x_q <= '0;
				spd_y_q <= '0;
			end else begin
				spd_x_q <= nspd_x;
				spd_y_q <= nspd_y;
			end
		end
	end

	assign ctl_out    = ctl_s1;
	assign cx_out     = cx_s1;
	assign cy_out     = cy_s1;
	assign sq_x_out   = sq_x_s1;
	assign sq_y_out   = sq_y_s1;
	assign cand_x_out = cand_x_s1;
	assign best_out   = best_s1;
	assign win_out    = win_s1;
	assign old_x_out  = old_x_s1;

endmodule

// File: rtl/centroid_tracker_line_cross_core.sv
// ----------------------------------------------------------------------------
// centroid_tracker_line_cross_core
// Nearest-neighbor centroid tracker with left-to-right line crossing report.
//
//   channel | handshake           | beat
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | box_x, box_y, box_width, box_height
//   out     | out_valid/out_stall | crossed, matched, added, dropped_full,
//           |                     | slot_index
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After accept the core squares the radius, launches the probe, moves it one
// hop per entry cell and then updates the entry; the result beat shows with
// that update. in_stall stays high from accept until the update, so a new
// box is taken only once the previous one has been updated. A result
// waiting under out_stall holds the update of the next box. Reset clears
// the entry count; entry contents are never read before they are written.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module centroid_tracker_line_cross_core #(
	parameter int unsigned MAX_OBJECTS = 16,
	parameter int unsigned COORD_BITS  = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ctl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [COORD_BITS-1:0]             box_x,
	input  logic [COORD_BITS-1:0]             box_y,
	input  logic [COORD_BITS-1:0]             box_width,
	input  logic [COORD_BITS-1:0]             box_height,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              crossed,
	output logic                              matched,
	output logic                              added,
	output logic                              dropped_full,
	output logic [ctl_pkg::SLOT_OUT_BITS-1:0] slot_index
);

	localparam int unsigned IW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int unsigned CW  = $clog2(MAX_OBJECTS + 1);
	localparam int unsigned DW  = COORD_BITS + 3;
	localparam int unsigned SQW = 2 * DW;
	localparam int unsigned SW  = SQW + 1;
	localparam int unsigned BW  = 2 * COORD_BITS;
	localparam int unsigned PW  = COORD_BITS + 1;
	localparam int unsigned SOW = ctl_pkg::SLOT_OUT_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_LAUNCH,
		S_SCAN,
		S_UPDATE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [COORD_BITS-1:0] mid_q, max_dist_q;
	logic           out_valid_q;
	logic           crossed_q, matched_q, added_q, dropped_q;
	logic [SOW-1:0] slot_q;

	logic [PW-1:0]  cx_q, cy_q;
	logic [BW-1:0]  limit_q;
	logic           found_q;
	logic [IW-1:0]  win_q;
	logic [PW-1:0]  old_x_q;

	ctl_pkg::ctl_probe_t ctl_w    [MAX_OBJECTS+1];
	logic [PW-1:0]       cx_w     [MAX_OBJECTS+1];
	logic [PW-1:0]       cy_w     [MAX_OBJECTS+1];
	logic [SQW-1:0]      sq_x_w   [MAX_OBJECTS+1];
	logic [SQW-1:0]      sq_y_w   [MAX_OBJECTS+1];
	logic [PW-1:0]       cand_x_w [MAX_OBJECTS+1];
	logic [BW-1:0]       best_w   [MAX_OBJECTS+1];
	logic [IW-1:0]       win_w    [MAX_OBJECTS+1];
	logic [PW-1:0]       old_x_w  [MAX_OBJECTS+1];

	ctl_pkg::ctl_wr_t wr;
	logic [IW-1:0]    wr_slot;
	logic             accept;
	logic             can_emit;
	logic             not_full;
	logic [SW-1:0]    tail_sum;
	logic             tail_take;
	logic             cross_now;
	logic [IW+SOW-1:0] win_ext, cnt_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign can_emit  = !out_valid_q || !out_stall;
	assign not_full  = count_q < CW'(MAX_OBJECTS);

	// launch the probe into the first cell
	assign ctl_w[0]    = '{live: (state_q == S_LAUNCH), found: 1'b0, cand: 1'b0};
	assign cx_w[0]     = cx_q;
	assign cy_w[0]     = cy_q;
	assign sq_x_w[0]   = '0;
	assign sq_y_w[0]   = '0;
	assign cand_x_w[0] = '0;
	assign best_w[0]   = limit_q;
	assign win_w[0]    = '0;
	assign old_x_w[0]  = '0;

	for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_cell
		ctl_cell #(
			.COORD_BITS (COORD_BITS),
			.IW         (IW),
			.CW         (CW),
			.SLOT       (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.count      (count_q),
			.wr         (wr),
			.wr_slot    (wr_slot),
			.wr_cx      (cx_q),
			.wr_cy      (cy_q),
			.ctl_in     (ctl_w[k]),
			.cx_in      (cx_w[k]),
			.cy_in      (cy_w[k]),
			.sq_x_in    (sq_x_w[k]),
			.sq_y_in    (sq_y_w[k]),
			.cand_x_in  (cand_x_w[k]),
			.best_in    (best_w[k]),
			.win_in     (win_w[k]),
			.old_x_in   (old_x_w[k]),
			.ctl_out    (ctl_w[k+1]),
			.cx_out     (cx_w[k+1]),
			.cy_out     (cy_w[k+1]),
			.sq_x_out   (sq_x_w[k+1]),
			.sq_y_out   (sq_y_w[k+1]),
			.cand_x_out (cand_x_w[k+1]),
			.best_out   (best_w[k+1]),
			.win_out    (win_w[k+1]),
			.old_x_out  (old_x_w[k+1])
		);
	end

	// fold in the last entry's distance
	assign tail_sum  = SW'(sq_x_w[MAX_OBJECTS]) + SW'(sq_y_w[MAX_OBJECTS]);
	assign tail_take = ctl_w[MAX_OBJECTS].cand && (tail_sum < SW'(best_w[MAX_OBJECTS]));

	assign wr.en   = (state_q == S_UPDATE) && can_emit && (found_q || not_full);
	assign wr.add  = !found_q;
	assign wr_slot = found_q ? win_q : count_q[IW-1:0];

	assign cross_now = (cx_q >= {1'b0, mid_q}) && (old_x_q < {1'b0, mid_q});
	assign win_ext   = {{SOW{1'b0}}, win_q};
	assign cnt_ext   = {{SOW{1'b0}}, count_q[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mid_q       <= '0;
			max_dist_q  <= COORD_BITS'(ctl_pkg::MAX_DIST_RESET);
			out_valid_q <= 1'b0;
			crossed_q   <= 1'b0;
			matched_q   <= 1'b0;
			added_q     <= 1'b0;
			dropped_q   <= 1'b0;
			slot_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (ctl_pkg::ctl_reg_t'(cfg_index))
					ctl_pkg::REG_MID_LINE_X:   mid_q      <= cfg_data;
					ctl_pkg::REG_MAX_DISTANCE: max_dist_q <= cfg_data;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_UPDATE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:    state_q <= S_LAUNCH;
				S_LAUNCH: state_q <= S_SCAN;
				S_SCAN: begin
					if (ctl_w[MAX_OBJECTS].live) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						crossed_q   <= found_q && cross_now;
						matched_q   <= found_q;
						added_q     <= !found_q && not_full;
						dropped_q   <= !found_q && !not_full;
						if (found_q) begin
							slot_q <= win_ext[SOW-1:0];
						end else if (not_full) begin
							slot_q  <= cnt_ext[SOW-1:0];
							count_q <= count_q + CW'(1);
						end else begin
							slot_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= PW'(box_x) + PW'(box_width >> 1);
			cy_q <= PW'(box_y) + PW'(box_height >> 1);
		end
		if (state_q == S_MUL) begin
			limit_q <= BW'(max_dist_q) * BW'(max_dist_q);
		end
		if (state_q == S_SCAN && ctl_w[MAX_OBJECTS].live) begin
			found_q <= ctl_w[MAX_OBJECTS].found | tail_take;
			win_q   <= tail_take ? IW'(MAX_OBJECTS - 1) : win_w[MAX_OBJECTS];
			old_x_q <= tail_take ? cand_x_w[MAX_OBJECTS] : old_x_w[MAX_OBJECTS];
		end
	end

	assign out_valid    = out_valid_q;
	assign crossed      = crossed_q;
	assign matched      = matched_q;
	assign added        = added_q;
	assign dropped_full = dropped_q;
	assign slot_index   = slot_q;

endmodule

// File: rtl/ctl_checker.sv
// ----------------------------------------------------------------------------
// ctl_checker
// Port-level checks of the centroid tracker result and input flow.
// ----------------------------------------------------------------------------
module ctl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              crossed,
	input logic                              matched,
	input logic                              added,
	input logic                              dropped_full,
	input logic [ctl_pkg::SLOT_OUT_BITS-1:0] slot_index
);

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({matched, added, dropped_full}))
		else $error("result beat must carry exactly one outcome");

	a_cross_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && crossed) |-> matched)
		else $error("crossing reported without a match");

	a_drop_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped_full) |-> (slot_index == '0))
		else $error("dropped box must report slot zero");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result beat dropped");

endmodule

bind centroid_tracker_line_cross_core ctl_checker u_ctl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.crossed      (crossed),
	.matched      (matched),
	.added        (added),
	.dropped_full (dropped_full),
	.slot_index   (slot_index)
);

// File: verif/centroid_tracker_line_cross_checker.sv
// ----------------------------------------------------------------------------
// centroid_tracker_line_cross_checker
// Passive scoreboard for the centroid tracker. It watches the register,
// box and result channels, keeps its own object table, predicts the result
// of every accepted box and compares it field by field with the result
// beats in order.
// ----------------------------------------------------------------------------
module centroid_tracker_line_cross_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ctl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [11:0]                       cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [11:0]                       box_x,
	input  logic [11:0]                       box_y,
	input  logic [11:0]                       box_width,
	input  logic [11:0]                       box_height,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              crossed,
	input  logic                              matched,
	input  logic                              added,
	input  logic                              dropped_full,
	input  logic [ctl_pkg::SLOT_OUT_BITS-1:0] slot_index,
	output int                                fail_count,
	output int                                results_seen,
	output int                                matched_seen,
	output int                                added_seen,
	output int                                dropped_seen,
	output int                                crossed_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;

	typedef struct {
		logic       crossed;
		logic       matched;
		logic       added;
		logic       dropped_full;
		logic [3:0] slot;
	} track_verdict_t;

	logic [11:0]        line_x;
	logic [11:0]        radius;
	logic [12:0]        obj_x [SLOTS];
	logic [12:0]        obj_y [SLOTS];
	logic signed [13:0] obj_vx [SLOTS];
	logic signed [13:0] obj_vy [SLOTS];
	int                 obj_count;
	track_verdict_t     verdict_q [$];
	track_verdict_t     due;
	int                 n_fail;

	assign fail_count = n_fail;

	function automatic track_verdict_t place_box(input logic [11:0] bx, input logic [11:0] by,
			input logic [11:0] bw, input logic [11:0] bh);
		track_verdict_t v;
		int             cx;
		int             cy;
		int             dx;
		int             dy;
		int             old_x;
		int             win;
		longint         dist_sq;
		longint         best;
		bit             found;
		cx = int'(bx) + int'(bw >> 1);
		cy = int'(by) + int'(bh >> 1);
		best = longint'(radius) * longint'(radius);
		found = 1'b0;
		win = 0;
		for (int i = 0; i < obj_count; i++) begin
			dx = int'(obj_x[i]) + int'(obj_vx[i]) - cx;
			dy = int'(obj_y[i]) + int'(obj_vy[i]) - cy;
			dist_sq = longint'(dx) * dx + longint'(dy) * dy;
			if (dist_sq < best) begin
				best = dist_sq;
				win = i;
				found = 1'b1;
			end
		end
		v = '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0};
		if (found) begin
			old_x = int'(obj_x[win]);
			obj_vx[win] = 14'(cx - old_x);
			obj_vy[win] = 14'(cy - int'(obj_y[win]));
			obj_x[win] = 13'(cx);
			obj_y[win] = 13'(cy);
			v.crossed = (cx >= int'(line_x)) && (old_x < int'(line_x));
			v.matched = 1'b1;
			v.slot = 4'(win);
		end else if (obj_count < SLOTS) begin
			obj_x[obj_count] = 13'(cx);
			obj_y[obj_count] = 13'(cy);
			obj_vx[obj_count] = '0;
			obj_vy[obj_count] = '0;
			v.added = 1'b1;
			v.slot = 4'(obj_count);
			obj_count++;
		end else begin
			v.dropped_full = 1'b1;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_x = '0;
			radius = 12'(ctl_pkg::MAX_DIST_RESET);
			obj_count = 0;
			verdict_q.delete();
			n_fail = 0;
			results_seen <= 0;
			matched_seen <= 0;
			added_seen <= 0;
			dropped_seen <= 0;
			crossed_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					if (n_fail < 10)
						$display("%0t: result beat with no box pending: %s",
							$realtime,
							$sformatf("c%b m%b a%b d%b slot %0d", crossed, matched,
								added, dropped_full, slot_index));
					n_fail++;
				end else begin
					due = verdict_q.pop_front();
					if (due.crossed !== crossed || due.matched !== matched ||
							due.added !== added || due.dropped_full !== dropped_full ||
							due.slot !== slot_index) begin
						if (n_fail < 10)
							$display("%0t: result %0d mismatch: want %s, got %s",
								$realtime, results_seen,
								$sformatf("c%b m%b a%b d%b slot %0d", due.crossed,
									due.matched, due.added, due.dropped_full, due.slot),
								$sformatf("c%b m%b a%b d%b slot %0d", crossed, matched,
									added, dropped_full, slot_index));
						n_fail++;
					end
				end
				results_seen <= results_seen + 1;
				matched_seen <= matched_seen + int'(matched);
				added_seen <= added_seen + int'(added);
				dropped_seen <= dropped_seen + int'(dropped_full);
				crossed_seen <= crossed_seen + int'(crossed);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctl_pkg::REG_MID_LINE_X:   line_x = cfg_data;
					ctl_pkg::REG_MAX_DISTANCE: radius = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(place_box(box_x, box_y, box_width, box_height));
		end
	end

endmodule

// File: verif/centroid_tracker_line_cross_core_tb.sv
// ----------------------------------------------------------------------------
// centroid_tracker_line_cross_core_tb
// Regression for the centroid tracker. A short directed run hits field
// extremes, matches, a left-to-right crossing, zero radius adds and a
// lowest-slot tie; then twelve objects are tracked along smooth paths mixed
// with random boxes across several register settings and flow-control modes.
// ----------------------------------------------------------------------------
module centroid_tracker_line_cross_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TRACKS = 12;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [ctl_pkg::CFG_IDX_BITS-1:0]    cfg_index;
	logic [11:0]                         cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [11:0]                         box_x;
	logic [11:0]                         box_y;
	logic [11:0]                         box_width;
	logic [11:0]                         box_height;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                crossed;
	logic                                matched;
	logic                                added;
	logic                                dropped_full;
	logic [ctl_pkg::SLOT_OUT_BITS-1:0]   slot_index;

	int fail_count;
	int results_seen;
	int matched_seen;
	int added_seen;
	int dropped_seen;
	int crossed_seen;

	int items_sent = 0;
	int settings_run = 1;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	int trk_x [TRACKS];
	int trk_y [TRACKS];
	int trk_vx [TRACKS];
	int trk_vy [TRACKS];

	centroid_tracker_line_cross_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.box_x        (box_x),
		.box_y        (box_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.crossed      (crossed),
		.matched      (matched),
		.added        (added),
		.dropped_full (dropped_full),
		.slot_index   (slot_index)
	);

	centroid_tracker_line_cross_checker tracker_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.box_x        (box_x),
		.box_y        (box_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.crossed      (crossed),
		.matched      (matched),
		.added        (added),
		.dropped_full (dropped_full),
		.slot_index   (slot_index),
		.fail_count   (fail_count),
		.results_seen (results_seen),
		.matched_seen (matched_seen),
		.added_seen   (added_seen),
		.dropped_seen (dropped_seen),
		.crossed_seen (crossed_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Timeout with %0d of %0d results seen", results_seen, items_sent);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_reqs != hold_served) begin
			hold_served++;
			hold_left = 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	function automatic int clamp(input int v, input int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	task automatic send_box(input logic [11:0] x, input logic [11:0] y,
			input logic [11:0] w, input logic [11:0] h);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		box_x <= x;
		box_y <= y;
		box_width <= w;
		box_height <= h;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic send_center(input int cx, input int cy);
		int bw;
		int bh;
		bw = $urandom_range(0, 400);
		bh = $urandom_range(0, 400);
		send_box(12'(cx - bw / 2), 12'(cy - bh / 2), 12'(bw), 12'(bh));
	endtask

	task automatic send_noise();
		send_box(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	task automatic set_tracking(input logic [11:0] mid, input logic [11:0] radius);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= ctl_pkg::REG_MID_LINE_X;
		cfg_data <= mid;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= ctl_pkg::REG_MAX_DISTANCE;
		cfg_data <= radius;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// advance one object along its path with a small velocity change
	task automatic step_track(input int k);
		int vx;
		int vy;
		int nx;
		int ny;
		vx = clamp(trk_vx[k] + $urandom_range(0, 6) - 3, 12);
		vy = clamp(trk_vy[k] + $urandom_range(0, 2) - 1, 2);
		nx = trk_x[k] + vx;
		if (nx < 300 || nx > 3800) begin
			vx = -vx;
			nx = trk_x[k] + vx;
		end
		ny = trk_y[k] + vy;
		if (ny < 300 || ny > 3800) begin
			vy = -vy;
			ny = trk_y[k] + vy;
		end
		trk_x[k] = nx;
		trk_y[k] = ny;
		trk_vx[k] = vx;
		trk_vy[k] = vy;
		send_center(nx, ny);
	endtask

	task automatic run_mix(input int count, input int noise_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise();
			else
				step_track($urandom_range(0, TRACKS - 1));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ctl_pkg::REG_MID_LINE_X;
		cfg_data = '0;
		in_valid = 1'b0;
		box_x = '0;
		box_y = '0;
		box_width = '0;
		box_height = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: line at 0, radius 20
		send_box(12'd0, 12'd0, 12'd0, 12'd0);
		send_box(12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_box(12'd0, 12'd0, 12'd1, 12'd1);
		send_box(12'd10, 12'd5, 12'd3, 12'd2);
		send_box(12'd22, 12'd12, 12'd0, 12'd0);

		// widest radius, move slot 0 across the line
		set_tracking(12'd100, 12'd4095);
		send_box(12'd200, 12'd12, 12'd0, 12'd0);

		// zero radius: a close pair of new objects
		set_tracking(12'd4095, 12'd0);
		send_box(12'd4095, 12'd100, 12'd2000, 12'd0);
		send_box(12'd4095, 12'd120, 12'd2000, 12'd0);

		// equal distance to both: lower slot takes it
		set_tracking(12'd2048, 12'd20);
		send_box(12'd4095, 12'd110, 12'd2000, 12'd0);

		// start the tracked objects near the line, mostly heading right
		set_tracking(12'd2048, 12'd60);
		for (int k = 0; k < TRACKS; k++) begin
			trk_x[k] = 2048 + $urandom_range(0, 80) - 40;
			trk_y[k] = 300 + k * 280;
			trk_vx[k] = $urandom_range(0, 14) - 4;
			trk_vy[k] = $urandom_range(0, 4) - 2;
			send_center(trk_x[k], trk_y[k]);
		end
		run_mix(100, 20);

		set_tracking(12'($urandom_range(1980, 2120)), 12'($urandom_range(40, 200)));
		snd_idle_pct = 72;
		run_mix(100, 20);

		set_tracking(12'($urandom_range(0, 4095)), 12'($urandom_range(40, 120)));
		snd_idle_pct = 0;
		rcv_stall_pct = 72;
		hold_reqs <= hold_reqs + 1;
		run_mix(100, 20);

		set_tracking(12'd0, 12'd0);
		snd_idle_pct = 21;
		rcv_stall_pct = 21;
		run_mix(25, 100);

		set_tracking(12'd4095, 12'd4095);
		run_mix(100, 20);

		drain();
		repeat (40) @(posedge clk);

		$display("Sent %0d boxes under %0d register settings and four flow-control modes",
			items_sent, settings_run);
		$display("Results: %0d matched, %0d added, %0d dropped on full table, %0d crossings",
			matched_seen, added_seen, dropped_seen, crossed_seen);
		if (fail_count == 0 && results_seen == items_sent) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results for %0d boxes", fail_count, results_seen,
				items_sent);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/ctl_pkg.sv
rtl/ctl_cell.sv
rtl/centroid_tracker_line_cross_core.sv
rtl/ctl_checker.sv
verif/centroid_tracker_line_cross_checker.sv
verif/centroid_tracker_line_cross_core_tb.sv
